>>> rtl/core/bflr_pkg.sv
`default_nettype none
package bflr_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_EDGES_DEF    = 8192;

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 13;
    localparam int DATA_W     = 14;
    localparam int DIST_W     = 30;
    localparam int ROUNDS_W   = 16;
    localparam int VCNT_W     = 11;
    localparam int MAXD_W     = 10;
    localparam int SRC_W      = 10;
    localparam int PRIO_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIST_W-1:0]   UNREACHED      = 30'h3FFF_FFFF;
    localparam logic [ROUNDS_W-1:0] MAX_ROUNDS_RST = 16'd1000;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_ROW  = 2'd0,
        CMD_WR_EDGE = 2'd1,
        CMD_RUN     = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE    = 3'd0,
        CFG_VCOUNT    = 3'd1,
        CFG_MAXROUNDS = 3'd2,
        CFG_STEP      = 3'd3,
        CFG_ASYNC     = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_INIT,
        S_SRC,
        S_RANGE,
        S_ECHK,
        S_ET,
        S_CMP,
        S_RSTART,
        S_VCHK,
        S_VEVAL,
        S_REND,
        S_SBEGIN,
        S_SCHK,
        S_SACC,
        S_RESP
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_RUN_INIT,
        OP_INIT_WR,
        OP_SRC_SETUP,
        OP_RANGE,
        OP_ET_RD,
        OP_CUR_RD_T,
        OP_E_NEXT,
        OP_RELAX,
        OP_ROUND_START,
        OP_V_RD,
        OP_V_NEXT,
        OP_V_RELAX,
        OP_MARK_ACTIVE,
        OP_ROUND_END,
        OP_STATS_START,
        OP_STATS_ACC,
        OP_STATS_END,
        OP_RESP
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd_code item_cmd;
        logic      init_last;
        logic      src_in;
        logic      v_lt_n;
        logic      range_empty;
        logic      is_active;
        logic      below_prio;
        logic      e_lt_hi;
        logic      t_in;
        logic      main;
        logic      keep_going;
        logic      out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

>>> rtl/core/bflr_ctrl.sv
`default_nettype none
module bflr_ctrl
    import bflr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_in_stall
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_sts.item_cmd == CMD_RUN) n_state = S_INIT;
                else n_state = S_RESP;
            end
            S_INIT: begin
                if (i_sts.init_last) n_state = S_SRC;
            end
            S_SRC: begin
                n_state = i_sts.src_in ? S_RANGE : S_RSTART;
            end
            S_RANGE: n_state = S_ECHK;
            S_ECHK: begin
                if (i_sts.e_lt_hi) n_state = S_ET;
                else if (i_sts.main) n_state = S_VCHK;
                else n_state = S_RSTART;
            end
            S_ET: begin
                n_state = i_sts.t_in ? S_CMP : S_ECHK;
            end
            S_CMP: n_state = S_ECHK;
            S_RSTART: n_state = S_VCHK;
            S_VCHK: begin
                n_state = i_sts.v_lt_n ? S_VEVAL : S_REND;
            end
            S_VEVAL: begin
                if (!i_sts.range_empty && i_sts.is_active && i_sts.below_prio) begin
                    n_state = S_ECHK;
                end else begin
                    n_state = S_VCHK;
                end
            end
            S_REND: begin
                n_state = i_sts.keep_going ? S_RSTART : S_SBEGIN;
            end
            S_SBEGIN: n_state = S_SCHK;
            S_SCHK: begin
                n_state = i_sts.v_lt_n ? S_SACC : S_RESP;
            end
            S_SACC: n_state = S_SCHK;
            S_RESP: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) o_cmd.op = OP_ACCEPT;
            end
            S_DISPATCH: begin
                if (i_sts.item_cmd == CMD_RUN) o_cmd.op = OP_RUN_INIT;
            end
            S_INIT: o_cmd.op = OP_INIT_WR;
            S_SRC: begin
                if (i_sts.src_in) o_cmd.op = OP_SRC_SETUP;
            end
            S_RANGE: o_cmd.op = OP_RANGE;
            S_ECHK: begin
                if (i_sts.e_lt_hi) o_cmd.op = OP_ET_RD;
                else if (i_sts.main) o_cmd.op = OP_V_NEXT;
            end
            S_ET: begin
                o_cmd.op = i_sts.t_in ? OP_CUR_RD_T : OP_E_NEXT;
            end
            S_CMP: o_cmd.op = OP_RELAX;
            S_RSTART: o_cmd.op = OP_ROUND_START;
            S_VCHK: begin
                if (i_sts.v_lt_n) o_cmd.op = OP_V_RD;
            end
            S_VEVAL: begin
                if (i_sts.range_empty || !i_sts.is_active) o_cmd.op = OP_V_NEXT;
                else if (i_sts.below_prio) o_cmd.op = OP_V_RELAX;
                else o_cmd.op = OP_MARK_ACTIVE;
            end
            S_REND: o_cmd.op = OP_ROUND_END;
            S_SBEGIN: o_cmd.op = OP_STATS_START;
            S_SCHK: begin
                o_cmd.op = i_sts.v_lt_n ? OP_V_RD : OP_STATS_END;
            end
            S_SACC: o_cmd.op = OP_STATS_ACC;
            S_RESP: begin
                if (i_sts.out_free) o_cmd.op = OP_RESP;
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/bflr_dpath.sv
`default_nettype none
module bflr_dpath
    import bflr_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd_s,
    output t_dp_sts                    o_sts,
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [ADDR_W-1:0]     i_addr,
    input  wire logic [DATA_W-1:0]     i_data,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output logic [DIST_W-1:0]          o_distance,
    output logic [ROUNDS_W-1:0]        o_rounds_taken,
    output logic [VCNT_W-1:0]          o_visited_count,
    output logic [MAXD_W-1:0]          o_max_distance,
    output logic                       o_done_res
);

    localparam int VA_W = $clog2(MAX_VERTICES);
    localparam int VC_W = $clog2(MAX_VERTICES + 1);
    localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W = $clog2(MAX_EDGES + 1);

    logic [DATA_W-1:0] m_row  [MAX_VERTICES+1];
    logic [DATA_W-1:0] m_edge [MAX_EDGES];
    logic [DIST_W-1:0] m_cur  [MAX_VERTICES];
    logic [DIST_W-1:0] m_set  [MAX_VERTICES];

    logic [SRC_W-1:0]      r_src;
    logic [VCNT_W-1:0]     r_vcount;
    logic [ROUNDS_W-1:0]   r_max_rounds;
    logic [ROUNDS_W-1:0]   r_step;
    logic                  r_async;

    t_cmd_code             r_cmd;
    logic [ADDR_W-1:0]     r_addr;
    logic [VC_W-1:0]       r_v;
    logic [EC_W-1:0]       r_e;
    logic [EC_W-1:0]       r_hi;
    logic [DATA_W-1:0]     r_ro_a;
    logic [DATA_W-1:0]     r_ro_b;
    logic [DATA_W-1:0]     r_et;
    logic [DIST_W-1:0]     r_cur_rd;
    logic [DIST_W-1:0]     r_set_rd;
    logic [DIST_W-1:0]     r_nd;
    logic [PRIO_W-1:0]     r_prio;
    logic                  r_active;
    logic                  r_main;
    logic [ROUNDS_W:0]     r_rounds;
    logic [VC_W-1:0]       r_vis;
    logic [DIST_W-1:0]     r_mx;
    logic [ROUNDS_W-1:0]   r_st_rounds;
    logic [VCNT_W-1:0]     r_st_vis;
    logic [MAXD_W-1:0]     r_st_max;
    logic                  r_out_valid;
    logic [DIST_W-1:0]     r_o_dist;
    logic [ROUNDS_W-1:0]   r_o_rounds;
    logic [VCNT_W-1:0]     r_o_vis;
    logic [MAXD_W-1:0]     r_o_max;

    logic [VC_W-1:0]       n_size;
    logic [DIST_W-1:0]     init_d;
    logic [VC_W-1:0]       row_sel;
    logic [EC_W-1:0]       rng_hi;
    logic [EC_W-1:0]       rng_lo;
    logic [ROUNDS_W:0]     rounds_inc;
    logic [VA_W-1:0]       cur_raddr;
    logic                  cur_ren;
    logic                  out_free;
    t_op                   op;

    assign op       = i_cmd_s.op;
    assign n_size   = (r_vcount > VCNT_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES)
                                                         : VC_W'(r_vcount);
    assign init_d   = (r_v < n_size && r_v == VC_W'(r_src)) ? '0 : UNREACHED;
    assign row_sel  = (op == OP_SRC_SETUP) ? VC_W'(r_src) : r_v;
    assign rng_hi   = (r_ro_b > DATA_W'(MAX_EDGES)) ? EC_W'(MAX_EDGES) : EC_W'(r_ro_b);
    assign rng_lo   = (r_ro_a > DATA_W'(rng_hi)) ? rng_hi : EC_W'(r_ro_a);
    assign rounds_inc = r_rounds[ROUNDS_W] ? r_rounds : r_rounds + 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        cur_ren   = 1'b1;
        cur_raddr = r_v[VA_W-1:0];
        unique case (op)
            OP_ACCEPT:   cur_raddr = VA_W'(i_addr);
            OP_V_RD:     cur_raddr = r_v[VA_W-1:0];
            OP_CUR_RD_T: cur_raddr = VA_W'(r_et);
            default:     cur_ren   = 1'b0;
        endcase
    end

    always_comb begin
        o_sts.item_cmd    = r_cmd;
        o_sts.init_last   = (r_v[VA_W-1:0] == VA_W'(MAX_VERTICES - 1));
        o_sts.src_in      = (VC_W'(r_src) < n_size);
        o_sts.v_lt_n      = r_v < n_size;
        o_sts.range_empty = rng_lo >= rng_hi;
        o_sts.is_active   = r_set_rd > r_cur_rd;
        o_sts.below_prio  = r_prio > PRIO_W'(r_cur_rd);
        o_sts.e_lt_hi     = r_e < r_hi;
        o_sts.t_in        = r_et < DATA_W'(n_size);
        o_sts.main        = r_main;
        o_sts.keep_going  = (r_async || rounds_inc < (ROUNDS_W+1)'(r_max_rounds)) && r_active;
        o_sts.out_free    = out_free;
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src        <= '0;
            r_vcount     <= VCNT_W'(1024);
            r_max_rounds <= MAX_ROUNDS_RST;
            r_step       <= '0;
            r_async      <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SOURCE:    r_src        <= i_cfg_data[SRC_W-1:0];
                CFG_VCOUNT:    r_vcount     <= i_cfg_data[VCNT_W-1:0];
                CFG_MAXROUNDS: r_max_rounds <= i_cfg_data;
                CFG_STEP:      r_step       <= i_cfg_data;
                CFG_ASYNC:     r_async      <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (op == OP_ACCEPT && i_cmd == CMD_WR_ROW && i_addr <= ADDR_W'(MAX_VERTICES)) begin
            m_row[VC_W'(i_addr)] <= i_data;
        end
        if (op == OP_SRC_SETUP || op == OP_V_RD) begin
            r_ro_a <= m_row[row_sel];
            r_ro_b <= m_row[row_sel + 1'b1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == OP_ACCEPT && i_cmd == CMD_WR_EDGE && 32'(i_addr) < MAX_EDGES) begin
            m_edge[EA_W'(i_addr)] <= i_data;
        end
        if (op == OP_ET_RD) begin
            r_et <= m_edge[EA_W'(r_e)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == OP_INIT_WR) begin
            m_cur[r_v[VA_W-1:0]] <= init_d;
        end else if (op == OP_RELAX && r_nd < r_cur_rd) begin
            m_cur[VA_W'(r_et)] <= r_nd;
        end
        if (cur_ren) begin
            r_cur_rd <= m_cur[cur_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == OP_INIT_WR) begin
            m_set[r_v[VA_W-1:0]] <= init_d;
        end else if (op == OP_V_RELAX) begin
            m_set[r_v[VA_W-1:0]] <= r_cur_rd;
        end
        if (op == OP_V_RD) begin
            r_set_rd <= m_set[r_v[VA_W-1:0]];
        end
    end

    // traversal state
    always_ff @(posedge i_clk) begin
        unique case (op)
            OP_ACCEPT: begin
                r_cmd  <= t_cmd_code'(i_cmd);
                r_addr <= i_addr;
            end
            OP_RUN_INIT: begin
                r_v    <= '0;
                r_prio <= (r_step == '0) ? '1 : '0;
            end
            OP_INIT_WR:   r_v <= r_v + 1'b1;
            OP_SRC_SETUP: begin
                r_nd   <= DIST_W'(1);
                r_main <= 1'b0;
            end
            OP_RANGE: begin
                r_e  <= rng_lo;
                r_hi <= rng_hi;
            end
            OP_E_NEXT, OP_RELAX: r_e <= r_e + 1'b1;
            OP_ROUND_START: begin
                r_prio   <= r_prio + PRIO_W'(r_step);
                r_active <= 1'b0;
                r_v      <= '0;
            end
            OP_V_NEXT: r_v <= r_v + 1'b1;
            OP_V_RELAX: begin
                r_active <= 1'b1;
                r_main   <= 1'b1;
                r_nd     <= r_cur_rd + 1'b1;
                r_e      <= rng_lo;
                r_hi     <= rng_hi;
            end
            OP_MARK_ACTIVE: begin
                r_active <= 1'b1;
                r_v      <= r_v + 1'b1;
            end
            OP_STATS_START: begin
                r_v   <= '0;
                r_vis <= '0;
                r_mx  <= '0;
            end
            OP_STATS_ACC: begin
                r_v <= r_v + 1'b1;
                if (r_cur_rd < UNREACHED) begin
                    r_vis <= r_vis + 1'b1;
                    if (r_cur_rd > r_mx) r_mx <= r_cur_rd;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rounds    <= '0;
            r_st_rounds <= '0;
            r_st_vis    <= '0;
            r_st_max    <= '0;
        end else begin
            if (op == OP_RUN_INIT) r_rounds <= (ROUNDS_W+1)'(1);
            if (op == OP_ROUND_END) r_rounds <= rounds_inc;
            if (op == OP_STATS_END) begin
                r_st_rounds <= r_rounds[ROUNDS_W] ? '1 : r_rounds[ROUNDS_W-1:0];
                r_st_vis    <= VCNT_W'(r_vis);
                r_st_max    <= r_mx[MAXD_W-1:0];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (op == OP_RESP) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == OP_RESP) begin
            if (r_cmd == CMD_READ) begin
                r_o_dist <= (r_addr < ADDR_W'(MAX_VERTICES)) ? r_cur_rd : UNREACHED;
            end else begin
                r_o_dist <= '0;
            end
            r_o_rounds <= r_st_rounds;
            r_o_vis    <= r_st_vis;
            r_o_max    <= r_st_max;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_distance      = r_o_dist;
    assign o_rounds_taken  = r_o_rounds;
    assign o_visited_count = r_o_vis;
    assign o_max_distance  = r_o_max;
    assign o_done_res      = 1'b1;

    a_relax_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op == OP_RELAX |-> $past(op) == OP_CUR_RD_T)
        else $error("relax without target read");

    a_edge_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op == OP_ET_RD |-> r_e < r_hi)
        else $error("edge index past range end");

    a_target_in_graph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op == OP_CUR_RD_T |-> r_et < DATA_W'(n_size))
        else $error("target outside graph");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op == OP_RESP |-> !r_out_valid || !i_out_stall)
        else $error("result overwritten while held");

endmodule
`default_nettype wire

>>> rtl/core/bfs_level_relaxation_engine.sv
`default_nettype none
// channel  | direction | handshake                  | payload
// in       | input     | i_in_valid / o_in_stall    | i_cmd, i_addr, i_data
// out      | output    | o_out_valid / i_out_stall  | o_distance, o_rounds_taken,
//          |           |                            | o_visited_count, o_max_distance,
//          |           |                            | o_done_res
// cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one item at a time; row/edge writes and distance reads go from dispatch to the result
// a run initialises both distance memories over all MAX_VERTICES entries, then per round
// scans each vertex and relaxes edges of active ones, then scans each vertex for statistics
// the cost is set by the single-port sequencing of the distance and edge memories
// synchronous active-low reset clears control and run statistics, not the memories
// a held result stalls nothing but the next result; o_in_stall is high while busy
module bfs_level_relaxation_engine
    import bflr_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [ADDR_W-1:0]     i_addr,
    input  wire logic [DATA_W-1:0]     i_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [DIST_W-1:0]          o_distance,
    output logic [ROUNDS_W-1:0]        o_rounds_taken,
    output logic [VCNT_W-1:0]          o_visited_count,
    output logic [MAXD_W-1:0]          o_max_distance,
    output logic                       o_done_res,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd_s;
    t_dp_sts sts_s;

    assign o_cfg_ready = 1'b1;

    bflr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts_s),
        .o_cmd      (cmd_s),
        .o_in_stall (o_in_stall)
    );

    bflr_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_s         (cmd_s),
        .o_sts           (sts_s),
        .i_cmd           (i_cmd),
        .i_addr          (i_addr),
        .i_data          (i_data),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_distance      (o_distance),
        .o_rounds_taken  (o_rounds_taken),
        .o_visited_count (o_visited_count),
        .o_max_distance  (o_max_distance),
        .o_done_res      (o_done_res)
    );

endmodule
`default_nettype wire
